[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on an explicit clock and active-low reset.
`define SVS_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error(msg);

// Same check on the module's own clk and rst_n.
`define SVS_ASSERT_CLK(lbl, prop, msg) \
  `SVS_ASSERT(lbl, clk, rst_n, prop, msg)

`endif

[src/svs_pkg.sv]
package svs_pkg;

  // Default sizing
  localparam int ZONES_DEF = 64;
  localparam int MAXV_DEF  = 16;

  // Field widths
  localparam int ZONE_IN_W = 6;
  localparam int ZONE_IN_N = 2 ** ZONE_IN_W;
  localparam int CNT_W     = 5;
  localparam int MODE_W    = 3;
  localparam int MASK_W    = 16;
  localparam int DRAW_W    = 16;
  localparam int IDX_W     = 4;
  localparam int IDX_N     = 2 ** IDX_W;

  // Special values: no index chosen yet, no variant played yet
  localparam logic [IDX_W-1:0] LAST_NONE   = IDX_W'(IDX_N - 1);
  localparam logic [CNT_W-1:0] PLAYED_NONE = CNT_W'(IDX_N);

  // Play modes
  localparam logic [MODE_W-1:0] MODE_RR     = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_RAND   = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_NOREP  = MODE_W'(2);
  localparam logic [MODE_W-1:0] MODE_CYCLE  = MODE_W'(3);
  localparam logic [MODE_W-1:0] MODE_UNISON = MODE_W'(4);

  // Remainder unit: quotient bits per cycle
  localparam int DIV_RADIX = 2;
  localparam int DIV_STEPS = DRAW_W / DIV_RADIX;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [ZONE_IN_W-1:0] zone_index;
    logic [CNT_W-1:0]     variant_count;
    logic [MODE_W-1:0]    play_mode;
    logic [MASK_W-1:0]    present_mask;
    logic                 skip;
    logic [DRAW_W-1:0]    rand_a;
    logic [DRAW_W-1:0]    rand_b;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0] variant_index;
    logic             has_variant;
    logic             start_voice;
  } out_t;

  // Per-zone state word
  typedef struct packed {
    logic [IDX_W-1:0] last_index;
    logic [CNT_W-1:0] bag_fill;
    logic [CNT_W-1:0] bag_size;
    logic [CNT_W-1:0] last_played;
  } zone_st_t;

  localparam zone_st_t ZONE_RST = '{
    last_index:  '0,
    bag_fill:    '0,
    bag_size:    '0,
    last_played: PLAYED_NONE
  };

  typedef struct packed {
    logic              start;
    logic [DRAW_W-1:0] dividend;
    logic [CNT_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] rem;
  } div_rsp_t;

endpackage

[src/sample_variant_selector.sv]
// Channel  | Ports                      | Handshake
// ---------+----------------------------+--------------------------------------
// input    | start, busy, in_data       | beat taken on start && !busy
// result   | out_valid, out_data        | one-cycle strobe, cannot be held off
//
// Skip, empty zone, unison and fixed-choice beats finish in the zone-read
// state, other picks after a remainder pass in svs_mod; a bag take adds two
// bag reads, a bag refill with a second draw a second pass. One beat is in
// flight at a time, bounded by the remainder unit and the bag memory port.
// After reset busy stays high while the zone memory is cleared.
// The result strobe and the next accept may share a cycle; results never stall.
`include "assert_macros.svh"

module sample_variant_selector
  import svs_pkg::*;
#(
  parameter int ZONES        = ZONES_DEF,
  parameter int MAX_VARIANTS = MAXV_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  localparam int NMAX      = (MAX_VARIANTS < IDX_N) ? MAX_VARIANTS : IDX_N;
  localparam int SW        = $clog2(NMAX);
  localparam int ZW        = (ZONES > 1) ? $clog2(ZONES) : 1;
  localparam int BAG_DEPTH = ZONES * (2 ** SW);
  localparam int BAG_AW    = $clog2(BAG_DEPTH);

  typedef enum logic [6:0] {
    S_CLR   = 7'b000_0001,
    S_IDLE  = 7'b000_0010,
    S_ZRD   = 7'b000_0100,
    S_DIV   = 7'b000_1000,
    S_FILLW = 7'b001_0000,
    S_BRD1  = 7'b010_0000,
    S_BRD2  = 7'b100_0000
  } state_t;

  typedef enum logic [2:0] {
    OP_RR,
    OP_RAND,
    OP_NOREP,
    OP_CYC_A,
    OP_CYC_B,
    OP_CYC_BAG
  } op_t;

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  in_t               item_r;
  logic [ZW-1:0]     zone_r;
  logic [CNT_W-1:0]  n_r;
  logic [SW-1:0]     slot_r, slot_nxt;
  logic [IDX_W-1:0]  chosen_r, chosen_nxt;
  logic [ZW-1:0]     clr_cnt_r;
  logic              fill_act_r;
  logic [SW-1:0]     fill_cnt_r;
  logic              out_valid_r;
  out_t              out_data_r, out_nxt;

  logic              fill_start;
  logic              fin, fin_plain;
  logic [IDX_W-1:0]  fin_idx;
  logic [IDX_W-1:0]  prev, prev_inc;
  logic [CNT_W-1:0]  n_m1;
  logic [CNT_W-1:0]  rem;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic              zone_we;
  logic [ZW-1:0]     zone_waddr, zone_raddr;
  zone_st_t          zone_wd, zone_rd;
  logic              bag_we;
  logic [BAG_AW-1:0] bag_waddr, bag_raddr;
  logic [IDX_W-1:0]  bag_wd, bag_rd;

  logic [ZW-1:0]     zone_lut [ZONE_IN_N];

  // Zone index wrap table
  for (genvar g = 0; g < ZONE_IN_N; g++) begin : g_zlut
    assign zone_lut[g] = ZW'(g % ZONES);
  end

  function automatic logic [BAG_AW-1:0] bag_addr(input logic [ZW-1:0] z,
                                                 input logic [SW-1:0] s);
    return BAG_AW'({z, s});
  endfunction

  // (a + 1 + b) mod n, with the sum known to stay below 2n
  function automatic logic [CNT_W-1:0] wrap_add(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b,
                                                input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] s;
    s = a + b + CNT_W'(1);
    return (s >= n) ? s - n : s;
  endfunction

  // Zone state memory
  svs_ram #(
    .DATA_W ($bits(zone_st_t)),
    .DEPTH  (ZONES)
  ) u_zone_ram (
    .clk   (clk),
    .we    (zone_we),
    .waddr (zone_waddr),
    .wdata (zone_wd),
    .raddr (zone_raddr),
    .rdata (zone_rd)
  );

  // Shuffle bag memory, one row of slots per zone
  svs_ram #(
    .DATA_W (IDX_W),
    .DEPTH  (BAG_DEPTH)
  ) u_bag_ram (
    .clk   (clk),
    .we    (bag_we),
    .waddr (bag_waddr),
    .wdata (bag_wd),
    .raddr (bag_raddr),
    .rdata (bag_rd)
  );

  // Shared draw-modulo-count unit
  svs_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign prev     = zone_rd.last_index;
  assign prev_inc = prev + IDX_W'(1);
  assign n_m1     = n_r - CNT_W'(1);
  assign rem      = div_rsp.rem;

  // Sequencer: read zone, pick, update bag, write back
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    slot_nxt   = slot_r;
    chosen_nxt = chosen_r;
    fill_start = 1'b0;
    fin        = 1'b0;
    fin_plain  = 1'b0;
    fin_idx    = '0;
    div_req    = '0;
    zone_we    = 1'b0;
    zone_waddr = zone_r;
    zone_wd    = zone_rd;
    zone_raddr = zone_r;
    bag_we     = 1'b0;
    bag_waddr  = bag_addr(zone_r, slot_r);
    bag_wd     = '0;
    bag_raddr  = bag_addr(zone_r, SW'(rem));

    case (state_r)
      S_CLR: begin
        zone_we    = 1'b1;
        zone_waddr = clr_cnt_r;
        zone_wd    = ZONE_RST;
        if (clr_cnt_r == ZW'(ZONES - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        zone_raddr = zone_lut[in_data.zone_index];
        if (start) begin
          state_nxt = S_ZRD;
        end
      end

      S_ZRD: begin
        if (item_r.skip) begin
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end else if (n_r == '0) begin
          fin                = 1'b1;
          zone_we            = 1'b1;
          zone_wd.last_index = LAST_NONE;
          state_nxt          = S_IDLE;
        end else if (n_r == CNT_W'(1) || item_r.play_mode == MODE_UNISON) begin
          fin_plain = 1'b1;
        end else if (n_r == CNT_W'(2) && item_r.play_mode != MODE_RAND) begin
          // two variants alternate
          fin_idx   = IDX_W'(!prev[0]);
          fin_plain = 1'b1;
        end else begin
          case (item_r.play_mode)
            MODE_RR: begin
              div_req.start    = 1'b1;
              div_req.dividend = DRAW_W'(prev_inc);
              div_req.divisor  = n_r;
              op_nxt           = OP_RR;
              state_nxt        = S_DIV;
            end
            MODE_RAND: begin
              div_req.start    = 1'b1;
              div_req.dividend = item_r.rand_a;
              div_req.divisor  = n_r;
              op_nxt           = OP_RAND;
              state_nxt        = S_DIV;
            end
            MODE_NOREP: begin
              div_req.start    = 1'b1;
              div_req.dividend = item_r.rand_a;
              state_nxt        = S_DIV;
              if (CNT_W'(prev) < n_r) begin
                div_req.divisor = n_m1;
                op_nxt          = OP_NOREP;
              end else begin
                div_req.divisor = n_r;
                op_nxt          = OP_RAND;
              end
            end
            MODE_CYCLE: begin
              div_req.start    = 1'b1;
              div_req.dividend = item_r.rand_a;
              state_nxt        = S_DIV;
              if (zone_rd.bag_fill == '0 || zone_rd.bag_size != n_r) begin
                // refill sweep runs beside the draw
                div_req.divisor = n_r;
                op_nxt          = OP_CYC_A;
                fill_start      = 1'b1;
              end else begin
                div_req.divisor = zone_rd.bag_fill;
                op_nxt          = OP_CYC_BAG;
              end
            end
            default: begin
              fin_idx   = prev;
              fin_plain = 1'b1;
            end
          endcase
        end
      end

      S_DIV: begin
        if (div_rsp.done) begin
          case (op_r)
            OP_RR, OP_RAND: begin
              fin_idx   = IDX_W'(rem);
              fin_plain = 1'b1;
            end
            OP_NOREP: begin
              fin_idx   = IDX_W'(wrap_add(CNT_W'(prev), rem, n_r));
              fin_plain = 1'b1;
            end
            OP_CYC_A: begin
              slot_nxt = SW'(rem);
              if (rem == zone_rd.last_played) begin
                // fresh bag would repeat: shift by a second draw
                div_req.start    = 1'b1;
                div_req.dividend = item_r.rand_b;
                div_req.divisor  = n_m1;
                op_nxt           = OP_CYC_B;
              end else begin
                state_nxt = S_FILLW;
              end
            end
            OP_CYC_B: begin
              slot_nxt  = SW'(wrap_add(CNT_W'(slot_r), rem, n_r));
              state_nxt = S_FILLW;
            end
            OP_CYC_BAG: begin
              slot_nxt  = SW'(rem);
              state_nxt = S_BRD1;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_FILLW: begin
        // fresh bag holds slot == value; last entry moves into the gap
        if (!fill_act_r) begin
          bag_we              = 1'b1;
          bag_waddr           = bag_addr(zone_r, slot_r);
          bag_wd              = IDX_W'(n_m1);
          fin_idx             = IDX_W'(slot_r);
          zone_wd.bag_fill    = n_m1;
          zone_wd.bag_size    = n_r;
          zone_wd.last_played = CNT_W'(fin_idx);
          fin_plain           = 1'b1;
        end
      end

      S_BRD1: begin
        chosen_nxt = bag_rd;
        bag_raddr  = bag_addr(zone_r, SW'(zone_rd.bag_fill - CNT_W'(1)));
        state_nxt  = S_BRD2;
      end

      S_BRD2: begin
        bag_we              = 1'b1;
        bag_waddr           = bag_addr(zone_r, slot_r);
        bag_wd              = bag_rd;
        fin_idx             = chosen_r;
        zone_wd.bag_fill    = zone_rd.bag_fill - CNT_W'(1);
        zone_wd.last_played = CNT_W'(chosen_r);
        fin_plain           = 1'b1;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // common finish: record chosen index
    if (fin_plain) begin
      fin                = 1'b1;
      zone_we            = 1'b1;
      zone_wd.last_index = fin_idx;
      state_nxt          = S_IDLE;
    end

    // refill sweep owns the bag write port while active
    if (fill_act_r) begin
      bag_we    = 1'b1;
      bag_waddr = bag_addr(zone_r, fill_cnt_r);
      bag_wd    = IDX_W'(fill_cnt_r);
    end
  end

  // Result word
  always_comb begin
    out_nxt.variant_index = fin_idx;
    out_nxt.has_variant   = !item_r.skip && (n_r != '0);
    out_nxt.start_voice   = !item_r.skip &&
                            ((n_r == '0) || item_r.present_mask[fin_idx]);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      fill_act_r  <= 1'b0;
      fill_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= fin;
      if (state_r == S_CLR) begin
        clr_cnt_r <= clr_cnt_r + ZW'(1);
      end
      if (fill_start) begin
        fill_act_r <= 1'b1;
        fill_cnt_r <= '0;
      end else if (fill_act_r) begin
        if (fill_cnt_r == SW'(n_m1)) begin
          fill_act_r <= 1'b0;
        end else begin
          fill_cnt_r <= fill_cnt_r + SW'(1);
        end
      end
    end
  end

  // Beat capture and working registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      item_r <= in_data;
      zone_r <= zone_lut[in_data.zone_index];
      n_r    <= (in_data.variant_count > CNT_W'(NMAX)) ? CNT_W'(NMAX)
                                                       : in_data.variant_count;
    end
    op_r     <= op_nxt;
    slot_r   <= slot_nxt;
    chosen_r <= chosen_nxt;
    if (fin) begin
      out_data_r <= out_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SVS_ASSERT_CLK(a_accept_busy, (start && !busy) |=> busy, "accepted beat did not raise busy")
  `SVS_ASSERT_CLK(a_out_idle, out_valid |-> (state_r == S_IDLE), "result strobe outside idle")
  `SVS_ASSERT_CLK(a_fill_le_size, (zone_we && state_r != S_CLR) |-> (zone_wd.bag_fill <= zone_wd.bag_size), "bag fill above bag size")
  `SVS_ASSERT_CLK(a_sweep_owned, fill_act_r |-> (state_r == S_DIV || state_r == S_FILLW), "refill sweep outside cycle pick")

endmodule

[src/svs_ram.sv]
module svs_ram
  import svs_pkg::*;
#(
  parameter int DATA_W = IDX_W,
  parameter int DEPTH  = ZONES_DEF
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [DATA_W-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [DATA_W-1:0]                         rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Single write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[src/svs_mod.sv]
`include "assert_macros.svh"

module svs_mod
  import svs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [DRAW_W-1:0] dnd_r;
  logic [CNT_W-1:0]  div_r;
  logic [CNT_W-1:0]  rem_r;
  logic [DRAW_W-1:0] dnd_nxt;
  logic [CNT_W-1:0]  rem_nxt;

  // Restoring remainder, DIV_RADIX dividend bits per cycle, MSB first
  always_comb begin
    logic [CNT_W-1:0] part;
    rem_nxt = rem_r;
    dnd_nxt = dnd_r;
    part    = '0;
    for (int k = 0; k < DIV_RADIX; k++) begin
      part    = {rem_nxt[CNT_W-2:0], dnd_nxt[DRAW_W-1]};
      dnd_nxt = dnd_nxt << 1;
      rem_nxt = (part >= div_r) ? part - div_r : part;
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + STEP_W'(1);
        if (cnt_r == STEP_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      dnd_r <= req.dividend;
      div_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dnd_r <= dnd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

  `SVS_ASSERT_CLK(a_rem_below_div, done_r |-> (rem_r < div_r), "remainder not below divisor")
  `SVS_ASSERT_CLK(a_no_restart, busy_r |-> !req.start, "remainder unit restarted while busy")

endmodule
